// ===== rtl/plpm_pkg.sv =====
package plpm_pkg;

    localparam int NUM_POINTS     = 16;
    localparam int SEG_W          = 4;
    localparam int FRAC_BITS      = 8;
    localparam int MM_W           = 7;
    localparam int POS_W          = 15;
    localparam int DX_W           = 11;
    localparam int RISE_W         = 3;
    localparam int PROD_W         = 14;
    localparam int RECIP_W        = 18;
    localparam int RECIP_SH       = 18;
    localparam int QUO_W          = 11;
    localparam int MULT_W         = PROD_W + RECIP_W;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam logic [MM_W-1:0] BRK_MM [NUM_POINTS] = '{
        7'd0,  7'd2,  7'd9,  7'd15, 7'd22, 7'd29, 7'd35, 7'd42,
        7'd48, 7'd54, 7'd60, 7'd66, 7'd71, 7'd77, 7'd83, 7'd85
    };

    localparam logic [MM_W-1:0] VAL_MM [NUM_POINTS] = '{
        7'd10, 7'd15, 7'd20, 7'd25, 7'd30, 7'd35, 7'd40, 7'd45,
        7'd50, 7'd55, 7'd60, 7'd65, 7'd70, 7'd75, 7'd80, 7'd85
    };

    // rise of the segment that starts at each breakpoint
    localparam logic [RISE_W-1:0] SEG_RISE [NUM_POINTS] = '{
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
        3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd0
    };

    // ceil(2^18 / span) for each segment; exact for every product below 2^14
    localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_POINTS] = '{
        18'd131072, 18'd37450, 18'd43691, 18'd37450,
        18'd37450,  18'd43691, 18'd37450, 18'd43691,
        18'd43691,  18'd43691, 18'd43691, 18'd52429,
        18'd43691,  18'd43691, 18'd131072, 18'd0
    };

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        logic [DX_W-1:0]  dx;
        logic             clamp;
    } t_item;

endpackage

// ===== rtl/piecewise_linear_position_map.sv =====
// An accepted request is written into the queue, then registered through back stages a, b and o before it strobes.
// Throughput: one request per cycle; the back pipeline drains the queue every cycle.
// busy rises only if the request queue fills, which the always-draining back end prevents.
// The receiver cannot stall: each result is shown for exactly one cycle.
// Reset is synchronous, active low, and clears the queue and all pipeline valids.
module piecewise_linear_position_map #(
    parameter int QUEUE_DEPTH = plpm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [plpm_pkg::POS_W-1:0] i_position_request,
    output logic                       o_strobe,
    output logic [plpm_pkg::POS_W-1:0] o_mapped_position,
    output logic                       o_clamped
);
    import plpm_pkg::*;

    t_item front_item;
    t_item queue_item;
    logic  queue_full;
    logic  queue_valid;
    logic  accept;

    assign busy   = queue_full;
    assign accept = start && !busy;

    plpm_front u_front (
        .i_position_request (i_position_request),
        .o_item             (front_item)
    );

    plpm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_item  (front_item),
        .o_full  (queue_full),
        .o_valid (queue_valid),
        .o_item  (queue_item)
    );

    plpm_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (queue_valid),
        .i_item            (queue_item),
        .o_strobe          (o_strobe),
        .o_mapped_position (o_mapped_position),
        .o_clamped         (o_clamped)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##4 o_strobe)
        else $error("request did not produce a result");

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !busy)
        else $error("queue backed up");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(accept, 4))
        else $error("result without request");

endmodule

// ===== rtl/plpm_front.sv =====
module plpm_front (
    input  logic [plpm_pkg::POS_W-1:0] i_position_request,
    output plpm_pkg::t_item            o_item
);
    import plpm_pkg::*;

    logic [POS_W-1:0] x;
    logic [POS_W-1:0] limit;
    logic [POS_W-1:0] base;
    logic [POS_W-1:0] dx_full;
    logic [SEG_W-1:0] seg;
    logic             clamp;

    always_comb begin
        limit = {BRK_MM[NUM_POINTS-1], {FRAC_BITS{1'b0}}};
        clamp = i_position_request > limit;
        x     = clamp ? limit : i_position_request;
        seg   = '0;
        for (int i = 0; i < NUM_POINTS; i++) begin
            if ({BRK_MM[i], {FRAC_BITS{1'b0}}} <= x) begin
                seg = SEG_W'(i);
            end
        end
        base    = {BRK_MM[seg], {FRAC_BITS{1'b0}}};
        dx_full = x - base;
        o_item.seg   = seg;
        o_item.dx    = dx_full[DX_W-1:0];
        o_item.clamp = clamp;
    end

endmodule

// ===== rtl/plpm_queue.sv =====
module plpm_queue #(
    parameter int DEPTH = plpm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  plpm_pkg::t_item i_item,
    output logic            o_full,
    output logic            o_valid,
    output plpm_pkg::t_item o_item
);
    import plpm_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_item            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_valid = r_count != '0;
    assign o_item  = r_mem[r_rd_ptr];
    assign pop     = o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("push into full queue");

    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_push && r_count == CNT_W'(1)) |=> !o_valid)
        else $error("queue failed to drain");

endmodule

// ===== rtl/plpm_back.sv =====
module plpm_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  plpm_pkg::t_item            i_item,
    output logic                       o_strobe,
    output logic [plpm_pkg::POS_W-1:0] o_mapped_position,
    output logic                       o_clamped
);
    import plpm_pkg::*;

    logic                r_a_valid;
    logic [PROD_W-1:0]   r_a_prod;
    logic [RECIP_W-1:0]  r_a_recip;
    logic [MM_W-1:0]     r_a_base;
    logic                r_a_clamp;

    logic                r_b_valid;
    logic [QUO_W-1:0]    r_b_quo;
    logic [MM_W-1:0]     r_b_base;
    logic                r_b_clamp;

    logic                r_o_valid;
    logic [POS_W-1:0]    r_o_pos;
    logic                r_o_clamp;

    logic [PROD_W-1:0]   n_a_prod;
    logic [MULT_W-1:0]   mult;
    logic [POS_W-1:0]    n_o_pos;

    assign n_a_prod = PROD_W'(i_item.dx) * PROD_W'(SEG_RISE[i_item.seg]);
    assign mult     = MULT_W'(r_a_prod) * MULT_W'(r_a_recip);
    assign n_o_pos  = {r_b_base, {FRAC_BITS{1'b0}}} + POS_W'(r_b_quo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
            r_o_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a_prod  <= n_a_prod;
        r_a_recip <= SEG_RECIP[i_item.seg];
        r_a_base  <= VAL_MM[i_item.seg];
        r_a_clamp <= i_item.clamp;
        r_b_quo   <= mult[RECIP_SH +: QUO_W];
        r_b_base  <= r_a_base;
        r_b_clamp <= r_a_clamp;
        r_o_pos   <= n_o_pos;
        r_o_clamp <= r_b_clamp;
    end

    assign o_strobe          = r_o_valid;
    assign o_mapped_position = r_o_pos;
    assign o_clamped         = r_o_clamp;

    a_pipe_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ##3 o_strobe)
        else $error("result lost in back pipeline");

    a_clamp_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_clamped) |-> o_mapped_position == {VAL_MM[NUM_POINTS-1],
        {FRAC_BITS{1'b0}}})
        else $error("clamped result not at end value");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid |-> r_b_quo < QUO_W'(1280))
        else $error("quotient out of range");

endmodule

// ===== dv/piecewise_linear_position_map_tb.sv =====
module piecewise_linear_position_map_tb;

    localparam int FRACTION      = 8;
    localparam int LAST_POINT    = 15;
    localparam int RANDOM_ITEMS  = 1730;
    localparam int QUIET_TAIL    = 200;
    localparam int DRAIN_AT      = 700;
    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 200000;

    typedef struct packed {
        logic [14:0] mapped;
        logic        clamped;
    } t_mapping;

    function automatic int opening_mm(int idx);
        case (idx)
            0: return 0;    1: return 2;    2: return 9;    3: return 15;
            4: return 22;   5: return 29;   6: return 35;   7: return 42;
            8: return 48;   9: return 54;   10: return 60;  11: return 66;
            12: return 71;  13: return 77;  14: return 83;  default: return 85;
        endcase
    endfunction

    function automatic int actuator_mm(int idx);
        return 10 + 5 * idx;
    endfunction

    class mapping_scoreboard;
        t_mapping pending_maps[$];
        int errors;
        int checked;
        int clamp_count;

        function t_mapping interpolate_position(logic [14:0] request);
            int x, lo, hi, i, b, xlo, base, span;
            bit found;
            t_mapping r;
            x = request;
            r.clamped = 1'b0;
            if (x > (opening_mm(LAST_POINT) << FRACTION)) begin
                x = opening_mm(LAST_POINT) << FRACTION;
                r.clamped = 1'b1;
            end
            lo = 0;
            hi = LAST_POINT;
            found = 1'b0;
            for (i = 0; i <= LAST_POINT; i++) begin
                if (!found) begin
                    b = opening_mm(i) << FRACTION;
                    if (b <= x) lo = i;
                    if (b >= x) begin
                        hi = i;
                        found = 1'b1;
                    end
                end
            end
            xlo  = opening_mm(lo) << FRACTION;
            base = actuator_mm(lo) << FRACTION;
            if (opening_mm(hi) <= opening_mm(lo) || x <= xlo) begin
                r.mapped = 15'(base);
            end else begin
                span = opening_mm(hi) - opening_mm(lo);
                if (actuator_mm(hi) >= actuator_mm(lo)) begin
                    r.mapped = 15'(base + (x - xlo) * (actuator_mm(hi) - actuator_mm(lo)) / span);
                end else begin
                    r.mapped = 15'(base - (x - xlo) * (actuator_mm(lo) - actuator_mm(hi)) / span);
                end
            end
            return r;
        endfunction

        function void note_request(logic [14:0] request);
            pending_maps.push_back(interpolate_position(request));
        endfunction

        function void check_result(logic [14:0] mapped, logic clamped);
            t_mapping exp_map;
            if (pending_maps.size() == 0) begin
                $error("result with no pending request: mapped_position %0d clamped %0d",
                       mapped, clamped);
                errors++;
                return;
            end
            exp_map = pending_maps.pop_front();
            checked++;
            if (exp_map.clamped) clamp_count++;
            if (mapped !== exp_map.mapped) begin
                $error("mapped_position: expected %0d, actual %0d", exp_map.mapped, mapped);
                errors++;
            end
            if (clamped !== exp_map.clamped) begin
                $error("clamped: expected %0d, actual %0d", exp_map.clamped, clamped);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [14:0] i_position_request = '0;
    logic        o_strobe;
    logic [14:0] o_mapped_position;
    logic        o_clamped;

    mapping_scoreboard sb;
    int cycle_count = 0;
    int sent = 0;

    piecewise_linear_position_map u_top (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_position_request (i_position_request),
        .o_strobe           (o_strobe),
        .o_mapped_position  (o_mapped_position),
        .o_clamped          (o_clamped)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_request(i_position_request);
        if (i_rst_n && o_strobe) sb.check_result(o_mapped_position, o_clamped);
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic send_request(logic [14:0] request, int idle);
        if (idle > 0) begin
            start <= 1'b0;
            i_position_request <= 15'($urandom);
            repeat (idle) @(posedge i_clk);
        end
        start <= 1'b1;
        i_position_request <= request;
        do @(posedge i_clk); while (busy);
        sent++;
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        do @(posedge i_clk); while (sb.pending_maps.size() != 0);
    endtask

    function automatic int random_idle();
        return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    endfunction

    function automatic logic [14:0] random_request();
        int sel, v;
        sel = $urandom_range(0, 9);
        if (sel < 6) begin
            v = $urandom_range(0, 85 << FRACTION);
        end else if (sel < 8) begin
            v = (opening_mm($urandom_range(0, LAST_POINT)) << FRACTION)
                + $urandom_range(0, 6) - 3;
            if (v < 0) v = 0;
        end else begin
            v = $urandom_range(0, 32767);
        end
        return v[14:0];
    endfunction

    initial begin
        int n;
        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n <= LAST_POINT; n++) send_request(15'(opening_mm(n) << FRACTION),
                                                        random_idle());
        send_request(15'd1, random_idle());
        send_request(15'd255, random_idle());
        send_request(15'd21759, random_idle());
        send_request(15'd21761, random_idle());
        send_request(15'd32767, random_idle());
        send_request(15'h2AAA, random_idle());
        send_request(15'h5555, random_idle());

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == DRAIN_AT) wait_for_results();
            send_request(random_request(), (n < RANDOM_ITEMS - QUIET_TAIL) ? random_idle() : 0);
        end

        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Sent %0d position requests (breakpoints, segment edges, full 15-bit range),",
                 sent);
        $display("checked %0d mapped results, %0d of them clamped.", sb.checked, sb.clamp_count);
        if (sb.errors == 0 && sb.pending_maps.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/plpm_pkg.sv
rtl/plpm_front.sv
rtl/plpm_queue.sv
rtl/plpm_back.sv
rtl/piecewise_linear_position_map.sv
dv/piecewise_linear_position_map_tb.sv
